/* sv/pfr_pkg.sv */
`timescale 1ns / 1ps

package pfr_pkg;

    // Field widths of one access.
    localparam int PID_W    = 8;
    localparam int PAGE_W   = 20;
    localparam int FRAMES_W = 7;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    // Default number of physical frames.
    localparam int NUM_FRAMES_DEF = 64;

    // Replacement policy codes.
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    // Reset value of the usable frame count.
    localparam logic [FRAMES_W-1:0] FRAMES_RST = 7'd64;

    // One stored page, as it moves along the row of cells.
    typedef struct packed {
        logic              valid;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
    } t_entry;

endpackage

/* sv/pfr_cell.sv */
`timescale 1ns / 1ps

module pfr_cell #(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift_en,
    input  logic [IDX_W-1:0] i_limit,
    input  pfr_pkg::t_entry  i_prev,
    input  pfr_pkg::t_entry  i_key,
    output pfr_pkg::t_entry  o_entry,
    output logic             o_match
);
    import pfr_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                r_valid;
    logic [PID_W-1:0]    r_pid;
    logic [PAGE_W-1:0]   r_page;
    logic                w_load;

    // A cell at or below the limit index takes its neighbor's entry.
    assign w_load = i_shift_en && (MY_IDX <= i_limit);

    // Valid bit, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_prev.valid;
        end
    end

    // Tag payload carries no reset.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pid  <= i_prev.pid;
            r_page <= i_prev.page;
        end
    end

    // Tag compare against the current access.
    assign o_match = r_valid && (r_pid == i_key.pid) && (r_page == i_key.page);

    assign o_entry.valid = r_valid;
    assign o_entry.pid   = r_pid;
    assign o_entry.page  = r_page;

endmodule

/* sv/page_frame_replacement_fifo_lru.sv */
`timescale 1ns / 1ps
// Output: the result of an access is presented in the cycle after its input transfer.
// Throughput: one access per cycle unless the output stalls; the limit is the tag compare
// and shift across the row of frame cells, which are kept in age order (newest first).
// Reset: the store is empty, the policy is FIFO and all frames are usable.
// No clearing pass is needed, so accesses are taken right after reset.

module page_frame_replacement_fifo_lru #(
    parameter int NUM_FRAMES = pfr_pkg::NUM_FRAMES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [pfr_pkg::FRAMES_W-1:0]   i_cfg_wdata,
    // Access stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: process_id[7:0], page_number[27:8], zero fill[31:28].
    input  logic [pfr_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: hit[0], evicted[1], zero fill[7:2].
    output logic [pfr_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import pfr_pkg::*;

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int CMP_W = (CNT_W > FRAMES_W) ? CNT_W : FRAMES_W;
    localparam logic [CMP_W-1:0] MAX_FRAMES = CMP_W'(NUM_FRAMES);
    localparam logic [CMP_W-1:0] ONE_FRAME  = CMP_W'(1);

    logic                  r_policy;
    logic [FRAMES_W-1:0]   r_frames;
    logic [CNT_W-1:0]      r_count;
    logic                  r_out_valid;
    logic                  r_hit;
    logic                  r_evicted;

    t_entry                w_key;
    t_entry                w_ent [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] w_match;
    logic [IDX_W-1:0]      w_hit_idx;
    logic [IDX_W-1:0]      w_limit;
    logic [CMP_W-1:0]      w_req;
    logic [CMP_W-1:0]      w_usable;
    logic                  w_hit;
    logic                  w_full;
    logic                  w_xfer;
    logic                  w_shift_en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_FIFO;
            r_frames <= FRAMES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POLICY: r_policy <= i_cfg_wdata[0];
                REG_FRAMES: r_frames <= i_cfg_wdata;
                default:    r_policy <= r_policy;
            endcase
        end
    end

    // Access key; the valid flag marks what enters the first cell.
    assign w_key.valid = 1'b1;
    assign w_key.pid   = s_axis_tdata[PID_W-1:0];
    assign w_key.page  = s_axis_tdata[PID_W+PAGE_W-1:PID_W];

    // Row of frame cells, newest at index zero.
    for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
        t_entry w_prev;
        if (k == 0) begin : g_head
            assign w_prev = w_key;
        end else begin : g_body
            assign w_prev = w_ent[k-1];
        end
        pfr_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift_en (w_shift_en),
            .i_limit    (w_limit),
            .i_prev     (w_prev),
            .i_key      (w_key),
            .o_entry    (w_ent[k]),
            .o_match    (w_match[k])
        );
    end

    // Position of the matching cell; at most one cell matches.
    always_comb begin
        w_hit_idx = '0;
        for (int k = 0; k < NUM_FRAMES; k++) begin
            if (w_match[k]) begin
                w_hit_idx = w_hit_idx | IDX_W'(k);
            end
        end
    end

    assign w_hit = |w_match;

    // Usable frame count, clamped to one through the store size.
    assign w_req = CMP_W'(r_frames);
    always_comb begin
        priority if (w_req == '0) begin
            w_usable = ONE_FRAME;
        end else if (w_req > MAX_FRAMES) begin
            w_usable = MAX_FRAMES;
        end else begin
            w_usable = w_req;
        end
    end

    assign w_full = CMP_W'(r_count) >= w_usable;

    // Handshake: a result waiting downstream stalls the input only if not taken.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_xfer        = s_axis_tvalid && s_axis_tready;

    // Shift up to the hit position (LRU only), the oldest resident or the first free cell.
    assign w_shift_en = w_xfer && (!w_hit || (r_policy == POLICY_LRU));
    always_comb begin
        priority if (w_hit) begin
            w_limit = w_hit_idx;
        end else if (w_full) begin
            w_limit = IDX_W'(r_count - CNT_W'(1));
        end else begin
            w_limit = IDX_W'(r_count);
        end
    end

    // Resident count grows only when a fault fills a free frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_xfer && !w_hit && !w_full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_hit     <= w_hit;
            r_evicted <= !w_hit && w_full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W - 2){1'b0}}, r_evicted, r_hit};

endmodule

/* tb/page_frame_replacement_fifo_lru_tb.sv */
`timescale 1ns / 1ps

module page_frame_replacement_fifo_lru_tb;

    import pfr_pkg::*;

    localparam int NUM_FRAMES   = NUM_FRAMES_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;

    // One access as the testbench holds it.
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [PID_W-1:0]  pid;
    } t_access;

    // One lookup outcome, in the bit order of the result stream.
    typedef struct packed {
        logic evicted;
        logic hit;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = REG_POLICY;
    logic [FRAMES_W-1:0]   i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    // Accesses waiting to be driven, and outcomes waiting to be seen.
    t_access  access_queue[$];
    t_outcome pending_outcomes[$];

    // Shadow copy of the frame store.
    bit                 frame_used  [NUM_FRAMES];
    logic [PID_W-1:0]   frame_owner [NUM_FRAMES];
    logic [PAGE_W-1:0]  frame_vpage [NUM_FRAMES];
    int                 frame_age   [NUM_FRAMES];
    int                 resident_total = 0;
    logic               model_policy = POLICY_FIFO;
    logic [FRAMES_W-1:0] model_frames = FRAMES_RST;

    int          mismatches = 0;
    int          results_seen = 0;
    int          gap_left = 0;
    int          source_calm = 0;
    int          stall_left = 0;
    int          sink_calm = 0;
    int unsigned cycle_count = 0;

    page_frame_replacement_fifo_lru i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Usable frame count after clamping the register to 1..NUM_FRAMES.
    function automatic int usable_frames();
        int n;
        n = int'(model_frames);
        if (n == 0) n = 1;
        if (n > NUM_FRAMES) n = NUM_FRAMES;
        return n;
    endfunction

    // Every resident frame younger than the given age gets one step older.
    function automatic void age_younger(int limit);
        int f;
        for (f = 0; f < NUM_FRAMES; f++)
            if (frame_used[f] && frame_age[f] < limit) frame_age[f]++;
    endfunction

    // Look the access up in the shadow store and apply the replacement policy.
    function automatic t_outcome lookup_page(t_access acc);
        t_outcome res;
        int       slot;
        int       f;
        res  = '0;
        slot = -1;
        for (f = 0; f < NUM_FRAMES; f++)
            if (slot < 0 && frame_used[f] && frame_owner[f] == acc.pid &&
                frame_vpage[f] == acc.page)
                slot = f;
        if (slot >= 0) begin
            // A hit only reorders under LRU.
            if (model_policy == POLICY_LRU) begin
                age_younger(frame_age[slot]);
                frame_age[slot] = 0;
            end
            res.hit = 1'b1;
            return res;
        end
        if (resident_total >= usable_frames()) begin
            // Full store: the oldest-ranked resident page is replaced.
            for (f = 0; f < NUM_FRAMES; f++)
                if (frame_used[f] && (slot < 0 || frame_age[f] > frame_age[slot]))
                    slot = f;
            age_younger(frame_age[slot]);
            res.evicted = 1'b1;
        end else begin
            // Free frame: the lowest-numbered empty one is filled.
            for (f = NUM_FRAMES - 1; f >= 0; f--)
                if (!frame_used[f]) slot = f;
            age_younger(NUM_FRAMES + 1);
            resident_total++;
        end
        frame_used[slot]  = 1'b1;
        frame_owner[slot] = acc.pid;
        frame_vpage[slot] = acc.page;
        frame_age[slot]   = 0;
        return res;
    endfunction

    // Idle length: mostly short, a few long, with calm stretches of none.
    function automatic int pick_idle(inout int calm_left);
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Source side: presents queued accesses and predicts each accepted one.
    always @(posedge i_clk) begin
        logic                valid_n;
        logic [S_DATA_W-1:0] data_n;
        valid_n = s_axis_tvalid;
        data_n  = s_axis_tdata;
        if (!i_rst_n) begin
            valid_n  = 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_outcomes.push_back(lookup_page(access_queue.pop_front()));
                valid_n = 1'b0;
            end
            if (!valid_n) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (access_queue.size() > 0) begin
                    valid_n  = 1'b1;
                    data_n   = {{(S_DATA_W - PID_W - PAGE_W){1'b0}},
                                access_queue[0].page, access_queue[0].pid};
                    gap_left = pick_idle(source_calm);
                end
            end
        end
        s_axis_tvalid <= valid_n;
        s_axis_tdata  <= data_n;
    end

    // Sink side: checks each result transfer and stalls at random.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            stall_left = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (pending_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d arrived with nothing expected: ",
                                  "hit=%0b evicted=%0b"},
                                 results_seen, m_axis_tdata[0], m_axis_tdata[1]);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_axis_tdata[0] !== want.hit || m_axis_tdata[1] !== want.evicted) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected hit=%0b evicted=%0b, ",
                                      "got hit=%0b evicted=%0b"},
                                     results_seen, want.hit, want.evicted,
                                     m_axis_tdata[0], m_axis_tdata[1]);
                    end
                end
                stall_left = pick_idle(sink_calm);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("page_frame_replacement_fifo_lru_tb NOT OK");
            $finish;
        end
    end

    task automatic queue_access(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page);
        t_access acc;
        acc.pid  = pid;
        acc.page = page;
        access_queue.push_back(acc);
    endtask

    // Block until every access has been transferred and every result seen.
    task automatic wait_idle();
        @(negedge i_clk);
        while (access_queue.size() != 0 || s_axis_tvalid || pending_outcomes.size() != 0)
            @(negedge i_clk);
    endtask

    // One register write, mirrored into the shadow configuration.
    task automatic write_register(input logic index, input logic [FRAMES_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        if (index == REG_POLICY)
            model_policy = value[0];
        else
            model_frames = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random accesses drawn mostly from a working set with near-miss tags.
    task automatic queue_random_phase(input int count);
        t_access pool[$];
        t_access acc;
        int      pool_size;
        int      k;
        int      pick;
        pool_size = usable_frames() + $urandom_range(0, usable_frames() / 2 + 3);
        for (k = 0; k < pool_size; k++) begin
            if (k == 0 || $urandom_range(0, 1) == 0) begin
                acc.pid  = PID_W'($urandom_range(0, 255));
                acc.page = PAGE_W'($urandom_range(0, 20'hFFFFF));
            end else begin
                acc = pool[$urandom_range(0, k - 1)];
                if ($urandom_range(0, 2) == 0)
                    acc.pid[$urandom_range(0, PID_W - 1)] ^= 1'b1;
                else
                    acc.page[$urandom_range(0, PAGE_W - 1)] ^= 1'b1;
            end
            pool.push_back(acc);
        end
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                acc.pid  = PID_W'($urandom_range(0, 255));
                acc.page = PAGE_W'($urandom_range(0, 20'hFFFFF));
            end else if (pick < 55) begin
                acc = pool[$urandom_range(0, pool_size / 4)];
            end else begin
                acc = pool[$urandom_range(0, pool_size - 1)];
            end
            access_queue.push_back(acc);
        end
    endtask

    // Stimulus sequence.
    initial begin
        int                  phase;
        logic [FRAMES_W-1:0] frames;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: field extremes, first loads and hits.
        queue_access(8'h00, 20'h00000);
        queue_access(8'hFF, 20'hFFFFF);
        queue_access(8'h00, 20'h00000);
        queue_access(8'hFF, 20'hFFFFF);
        queue_access(8'h00, 20'hFFFFF);
        queue_access(8'hFF, 20'h00000);
        queue_access(8'hAA, 20'h55555);
        queue_access(8'h55, 20'hAAAAA);

        // Frame count lowered below the residents: faults replace the oldest load.
        wait_idle();
        write_register(REG_FRAMES, 7'd2);
        queue_access(8'h01, 20'h00001);
        queue_access(8'h00, 20'h00000);
        queue_access(8'hFF, 20'hFFFFF);
        queue_access(8'h02, 20'h00002);

        // LRU with a frame count of zero, which acts as one frame.
        wait_idle();
        write_register(REG_POLICY, FRAMES_W'(POLICY_LRU));
        write_register(REG_FRAMES, 7'd0);
        queue_access(8'h03, 20'h00003);
        queue_access(8'h03, 20'h00003);
        queue_access(8'h04, 20'h00004);
        queue_access(8'h03, 20'h00003);

        // LRU over three frames: a hit protects the page from the next fault.
        wait_idle();
        write_register(REG_FRAMES, 7'd3);
        queue_access(8'h10, 20'h00010);
        queue_access(8'h11, 20'h00011);
        queue_access(8'h12, 20'h00012);
        queue_access(8'h10, 20'h00010);
        queue_access(8'h13, 20'h00013);
        queue_access(8'h11, 20'h00011);
        queue_access(8'h10, 20'h00010);

        // Oversized frame count, back to FIFO mid-run.
        wait_idle();
        write_register(REG_POLICY, FRAMES_W'(POLICY_FIFO));
        write_register(REG_FRAMES, 7'd127);
        queue_access(8'h20, 20'h00020);
        queue_access(8'h10, 20'h00010);

        // Random phases over a spread of settings.
        for (phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 7))
                0: frames = 7'd0;
                1: frames = 7'd1;
                2: frames = FRAMES_W'($urandom_range(2, 8));
                3: frames = FRAMES_W'($urandom_range(9, 40));
                4: frames = 7'd63;
                5: frames = 7'd64;
                6: frames = FRAMES_W'($urandom_range(65, 127));
                default: frames = FRAMES_W'($urandom_range(0, 127));
            endcase
            wait_idle();
            write_register(REG_POLICY, FRAMES_W'(phase[0] ? POLICY_LRU : POLICY_FIFO));
            write_register(REG_FRAMES, frames);
            queue_random_phase(PHASE_ITEMS);
        end

        // Drain, then allow for any stray late result.
        wait_idle();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("page_frame_replacement_fifo_lru_tb OK");
        end else begin
            $display("page_frame_replacement_fifo_lru_tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/pfr_pkg.sv
sv/pfr_cell.sv
sv/page_frame_replacement_fifo_lru.sv
tb/page_frame_replacement_fifo_lru_tb.sv
